FILE: sv/rtlp_pkg.sv
// ----------------------------------------------------------------------------
// rtlp_pkg
// Shared types and codes of the longest prefix match route table.
// ----------------------------------------------------------------------------
package rtlp_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [4:0] METRIC_MAX = 5'd16;
    localparam logic [31:0] ORDER_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] route_network;
        logic [31:0] route_mask;
        logic [31:0] next_hop;
        logic [31:0] interface_addr;
        logic [4:0]  route_metric;
        logic [15:0] route_lifetime;
        logic [31:0] lookup_address;
        logic [5:0]  slot_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  found_slot;
        logic [31:0] hit_network;
        logic [31:0] hit_mask;
        logic [31:0] hit_next_hop;
        logic [31:0] hit_interface;
        logic [4:0]  hit_metric;
        logic [15:0] hit_lifetime;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [31:0] network;
        logic [31:0] mask;
        logic [31:0] next_hop;
        logic [31:0] interface_addr;
        logic [4:0]  metric;
        logic [15:0] lifetime;
        logic [31:0] order;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS,
        ST_LKP,
        ST_LKP_END,
        ST_REM_RD,
        ST_REM_CHK,
        ST_DONE
    } t_state;

endpackage

FILE: sv/rtlp_if.sv
// ----------------------------------------------------------------------------
// rtlp_req_if / rtlp_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface rtlp_req_if;
    logic          valid;
    logic          ready;
    rtlp_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtlp_rsp_if;
    logic          valid;
    logic          ready;
    rtlp_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/rtlp_mem.sv
// ----------------------------------------------------------------------------
// rtlp_mem
// Route entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtlp_mem #(
    parameter int TABLE_DEPTH = rtlp_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  rtlp_pkg::t_entry   i_wdata,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    output rtlp_pkg::t_entry   o_rdata
);

    rtlp_pkg::t_entry mem [TABLE_DEPTH];
    rtlp_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rtlp_ctrl.sv
// ----------------------------------------------------------------------------
// rtlp_ctrl
// Command sequencer: clearing pass, free slot scan, remove, prefix scan.
// ----------------------------------------------------------------------------
module rtlp_ctrl #(
    parameter int TABLE_DEPTH = rtlp_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rtlp_req_if.sink          i_req,
    rtlp_rsp_if.source        o_rsp,
    output logic              o_mem_we,
    output logic [ADDR_W-1:0] o_mem_waddr,
    output rtlp_pkg::t_entry  o_mem_wdata,
    output logic              o_mem_re,
    output logic [ADDR_W-1:0] o_mem_raddr,
    input  rtlp_pkg::t_entry  i_mem_rdata
);

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_DEPTH - 1);

    rtlp_pkg::t_state r_state, n_state;
    rtlp_pkg::t_req   r_req, n_req;
    rtlp_pkg::t_rsp   r_res, n_res;
    rtlp_pkg::t_rsp   r_out, n_out;
    rtlp_pkg::t_entry r_best, n_best;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ADDR_W-1:0] r_chk_addr, n_chk_addr;
    logic [ADDR_W-1:0] r_best_addr, n_best_addr;
    logic              r_more, n_more;
    logic              r_chk, n_chk;
    logic              r_have, n_have;
    logic [31:0]       r_order, n_order;

    logic [31:0]       w_rem32;
    logic [31:0]       w_chk32;
    logic [31:0]       w_best32;
    logic              w_match;
    logic              w_better;
    logic [4:0]        w_metric;
    rtlp_pkg::t_entry  w_new;

    assign w_rem32  = 32'(i_req.data.slot_index);
    assign w_chk32  = 32'(r_chk_addr);
    assign w_best32 = 32'(r_best_addr);

    assign w_match = i_mem_rdata.valid &&
        ((i_mem_rdata.network & i_mem_rdata.mask) ==
         (r_req.lookup_address & i_mem_rdata.mask));
    assign w_better = w_match && (!r_have || (i_mem_rdata.mask > r_best.mask) ||
        ((i_mem_rdata.mask == r_best.mask) && (i_mem_rdata.order < r_best.order)));

    assign w_metric = (r_req.route_metric > rtlp_pkg::METRIC_MAX) ?
                      rtlp_pkg::METRIC_MAX : r_req.route_metric;

    always_comb begin
        w_new.valid          = 1'b1;
        w_new.network        = r_req.route_network;
        w_new.mask           = r_req.route_mask;
        w_new.next_hop       = r_req.next_hop;
        w_new.interface_addr = r_req.interface_addr;
        w_new.metric         = w_metric;
        w_new.lifetime       = r_req.route_lifetime;
        w_new.order          = r_order;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rtlp_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
            r_more      <= 1'b0;
            r_chk       <= 1'b0;
            r_have      <= 1'b0;
            r_order     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_addr      <= n_addr;
            r_more      <= n_more;
            r_chk       <= n_chk;
            r_have      <= n_have;
            r_order     <= n_order;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_res       <= n_res;
        r_out       <= n_out;
        r_best      <= n_best;
        r_chk_addr  <= n_chk_addr;
        r_best_addr <= n_best_addr;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_best      = r_best;
        n_out_valid = r_out_valid;
        n_addr      = r_addr;
        n_chk_addr  = r_chk_addr;
        n_best_addr = r_best_addr;
        n_more      = r_more;
        n_chk       = 1'b0;
        n_have      = r_have;
        n_order     = r_order;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_chk_addr;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_addr;
        i_req.ready = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        if ((r_state == rtlp_pkg::ST_INS || r_state == rtlp_pkg::ST_LKP) && r_more) begin
            o_mem_re   = 1'b1;
            n_chk      = 1'b1;
            n_chk_addr = r_addr;
            n_addr     = r_addr + ADDR_W'(1);
            n_more     = (r_addr != LAST);
        end

        unique case (r_state)
            rtlp_pkg::ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_addr;
                o_mem_wdata = '0;
                n_addr      = r_addr + ADDR_W'(1);
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = rtlp_pkg::ST_IDLE;
                end
            end
            rtlp_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_req  = i_req.data;
                    n_res  = '0;
                    n_have = 1'b0;
                    n_addr = '0;
                    n_more = 1'b1;
                    unique case (i_req.data.command)
                        rtlp_pkg::CMD_INSERT: n_state = rtlp_pkg::ST_INS;
                        rtlp_pkg::CMD_LOOKUP: n_state = rtlp_pkg::ST_LKP;
                        rtlp_pkg::CMD_REMOVE: begin
                            n_res.found_slot = i_req.data.slot_index;
                            if (w_rem32 < 32'(TABLE_DEPTH)) begin
                                n_addr  = w_rem32[ADDR_W-1:0];
                                n_state = rtlp_pkg::ST_REM_RD;
                            end else begin
                                n_res.status = rtlp_pkg::STATUS_MISS;
                                n_state      = rtlp_pkg::ST_DONE;
                            end
                        end
                        default: begin
                            n_res.status = rtlp_pkg::STATUS_MISS;
                            n_state      = rtlp_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            rtlp_pkg::ST_INS: begin
                if (r_chk) begin
                    if (!i_mem_rdata.valid) begin
                        o_mem_we         = 1'b1;
                        o_mem_wdata      = w_new;
                        n_order          = (r_order == rtlp_pkg::ORDER_MAX) ?
                                           r_order : r_order + 32'd1;
                        n_res.status     = rtlp_pkg::STATUS_OK;
                        n_res.found_slot = w_chk32[5:0];
                        n_more           = 1'b0;
                        n_state          = rtlp_pkg::ST_DONE;
                    end else if (r_chk_addr == LAST) begin
                        n_res.status = rtlp_pkg::STATUS_FULL;
                        n_state      = rtlp_pkg::ST_DONE;
                    end
                end
            end
            rtlp_pkg::ST_LKP: begin
                if (r_chk) begin
                    if (w_better) begin
                        n_have      = 1'b1;
                        n_best      = i_mem_rdata;
                        n_best_addr = r_chk_addr;
                    end
                    if (r_chk_addr == LAST) begin
                        n_state = rtlp_pkg::ST_LKP_END;
                    end
                end
            end
            rtlp_pkg::ST_LKP_END: begin
                if (r_have) begin
                    n_res.status        = rtlp_pkg::STATUS_OK;
                    n_res.found_slot    = w_best32[5:0];
                    n_res.hit_network   = r_best.network;
                    n_res.hit_mask      = r_best.mask;
                    n_res.hit_next_hop  = r_best.next_hop;
                    n_res.hit_interface = r_best.interface_addr;
                    n_res.hit_metric    = r_best.metric;
                    n_res.hit_lifetime  = r_best.lifetime;
                end else begin
                    n_res.status = rtlp_pkg::STATUS_MISS;
                end
                n_state = rtlp_pkg::ST_DONE;
            end
            rtlp_pkg::ST_REM_RD: begin
                o_mem_re   = 1'b1;
                n_chk_addr = r_addr;
                n_state    = rtlp_pkg::ST_REM_CHK;
            end
            rtlp_pkg::ST_REM_CHK: begin
                if (i_mem_rdata.valid) begin
                    o_mem_we          = 1'b1;
                    o_mem_wdata.valid = 1'b0;
                    n_res.status      = rtlp_pkg::STATUS_OK;
                end else begin
                    n_res.status = rtlp_pkg::STATUS_MISS;
                end
                n_state = rtlp_pkg::ST_DONE;
            end
            rtlp_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = rtlp_pkg::ST_IDLE;
                end
            end
            default: n_state = rtlp_pkg::ST_IDLE;
        endcase
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

`ifndef SYNTHESIS
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rtlp_pkg::ST_LKP || r_state == rtlp_pkg::ST_LKP_END) |-> !o_mem_we)
        else $error("table written during lookup scan");
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == rtlp_pkg::ST_DONE)
        else $error("response loaded outside completion");
    a_order_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_order >= $past(r_order))
        else $error("order counter went backwards");
    a_clear_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rtlp_pkg::ST_CLEAR) |-> (!o_mem_re && !i_req.ready))
        else $error("access during clearing pass");
`endif

endmodule

FILE: sv/route_table_longest_prefix_match_top.sv
// ----------------------------------------------------------------------------
// route_table_longest_prefix_match_top
// IPv4 route table with insert, remove and longest prefix match lookup.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one command per transaction (insert, remove, lookup);
//   o_rsp returns exactly one response transaction per request, in order.
//   Commands run one at a time; i_req.ready is high only between commands.
//   Insert: scans slots one per cycle through the entry memory read port
//   until a free one is found, or answers STATUS_FULL after the last slot.
//   Lookup: scans all TABLE_DEPTH slots, one memory read per cycle, keeping
//   the best match in registers.
//   Remove: one read, then a write back that clears the valid bit if the
//   slot was valid. An out of range remove or an unknown command answers MISS.
//   Reset: a clearing pass over all TABLE_DEPTH slots marks every slot empty;
//   i_req.ready stays low until it ends.
//   Stall: the response register holds a finished result while the next
//   command runs; a command that finishes before o_rsp is taken waits for it.
// ----------------------------------------------------------------------------
module route_table_longest_prefix_match_top #(
    parameter int TABLE_DEPTH = rtlp_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtlp_req_if.sink    i_req,
    rtlp_rsp_if.source  o_rsp
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    rtlp_pkg::t_entry  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    rtlp_pkg::t_entry  mem_rdata;

    rtlp_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    rtlp_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
